@@ src/waypoint_velocity_follower_defines.svh @@
// Assertion macros for the waypoint velocity follower.
// Used by the top level only; no other dependencies.
`ifndef WAYPOINT_VELOCITY_FOLLOWER_DEFINES_SVH
`define WAYPOINT_VELOCITY_FOLLOWER_DEFINES_SVH
`ifndef SYNTHESIS
`define WVF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define WVF_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define WVF_ASSERT_IMPL(label, clk, rst, prop)
`define WVF_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ src/wvf_pkg.sv @@
// Shared types and constants for the waypoint velocity follower.
// No dependencies.
package wvf_pkg;
   localparam logic [1:0] MODE_POS   = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] REG_DELAY  = 2'd0;
   localparam logic [1:0] REG_SPEED  = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   localparam logic [20:0] SPEED_MAX = 21'd1048576;

   // Datapath operations started by the controller.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_LOAD   = 3'd1,  // latch offset from store read data
      OP_SQ     = 3'd2,  // one squaring step
      OP_NORM   = 3'd3,  // one normalizing shift
      OP_SQRT   = 3'd4,  // one root step
      OP_DIV    = 3'd5,  // one restoring divide step (both components)
      OP_INIT   = 3'd6,  // set up divide
      OP_PRIME  = 3'd7   // clear the sum and set up the root unit
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_y;  // squaring: which component
   } cmd_type;

   typedef struct packed {
      logic near;      // inside the threshold disc
      logic zero;      // offset is zero
      logic norm_done; // max magnitude in [2^29, 2^30)
   } stat_type;
endpackage

@@ src/wvf_if.sv @@
// Valid/ready channel carrying one item.
// Depends on nothing; payload width set by parameter.
interface wvf_if #(parameter int W = 66);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/wvf_datapath.sv @@
// Arithmetic for one control tick: offset, threshold test, normalize,
// square root and division. Depends on wvf_pkg.
module wvf_datapath (
   input  logic                clock,
   input  wvf_pkg::cmd_type    cmd,
   input  logic [31:0]         wp_x,
   input  logic [31:0]         wp_y,
   input  logic [31:0]         cur_x,
   input  logic [31:0]         cur_y,
   input  logic [24:0]         thresh,
   input  logic [20:0]         speed,
   output wvf_pkg::stat_type   stat,
   output logic [21:0]         vel_x,
   output logic [21:0]         vel_y
);
   logic [32:0] ax_ff, ay_ff;
   logic        nx_ff, ny_ff;
   logic [63:0] q_ff;          // sum of squares / root remainder
   logic [63:0] root_ff;
   logic [63:0] bit_ff;
   logic [51:0] remx_ff, remy_ff;
   logic [51:0] numx_ff, numy_ff;
   logic [21:0] qx_ff, qy_ff;
   logic [32:0] dx, dy, m;
   logic [59:0] prod;
   logic [49:0] thr_sq;
   logic [50:0] pnx, pny;
   logic [20:0] spd;
   logic [63:0] trial;
   logic [52:0] rx, ry;

   assign dx = {wp_x[31], wp_x} - {cur_x[31], cur_x};
   assign dy = {wp_y[31], wp_y} - {cur_y[31], cur_y};
   assign m  = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign spd = (speed > wvf_pkg::SPEED_MAX) ? wvf_pkg::SPEED_MAX : speed;
   // The threshold test only matters when both magnitudes are below 2^25;
   // after normalizing both lie below 2^30.
   assign prod = cmd.sel_y ? 60'(ay_ff[29:0]) * 60'(ay_ff[29:0])
                           : 60'(ax_ff[29:0]) * 60'(ax_ff[29:0]);
   assign thr_sq = 50'(thresh) * 50'(thresh);
   assign pnx = 51'(spd) * 51'(ax_ff[29:0]);
   assign pny = 51'(spd) * 51'(ay_ff[29:0]);
   assign trial = root_ff + bit_ff;
   assign rx = {remx_ff, numx_ff[51]};
   assign ry = {remy_ff, numy_ff[51]};

   always_comb begin
      stat.zero = (ax_ff == '0) && (ay_ff == '0);
      stat.near = (ax_ff < {8'd0, thresh}) && (ay_ff < {8'd0, thresh}) &&
                  (q_ff < 64'(thr_sq));
      stat.norm_done = (m[32:30] == 3'd0) && m[29];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         wvf_pkg::OP_LOAD: begin
            nx_ff <= dx[32];
            ny_ff <= dy[32];
            ax_ff <= dx[32] ? -dx : dx;
            ay_ff <= dy[32] ? -dy : dy;
            q_ff  <= '0;
         end
         wvf_pkg::OP_SQ: q_ff <= q_ff + 64'(prod);
         wvf_pkg::OP_PRIME: begin
            q_ff    <= '0;
            root_ff <= '0;
            bit_ff  <= 64'd1 << 62;
         end
         wvf_pkg::OP_NORM: begin
            if (m[32:30] != 3'd0) begin
               ax_ff <= ax_ff >> 1;
               ay_ff <= ay_ff >> 1;
            end else begin
               ax_ff <= ax_ff << 1;
               ay_ff <= ay_ff << 1;
            end
         end
         wvf_pkg::OP_SQRT: begin
            // The normalized sum of squares sits in q_ff at this point.
            if (q_ff >= trial) begin
               q_ff    <= q_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         wvf_pkg::OP_INIT: begin
            numx_ff <= 52'(pnx) + 52'(root_ff >> 1);
            numy_ff <= 52'(pny) + 52'(root_ff >> 1);
            remx_ff <= '0;
            remy_ff <= '0;
         end
         wvf_pkg::OP_DIV: begin
            numx_ff <= numx_ff << 1;
            numy_ff <= numy_ff << 1;
            if (rx >= 53'(root_ff)) begin
               remx_ff <= 52'(rx - 53'(root_ff));
               qx_ff   <= {qx_ff[20:0], 1'b1};
            end else begin
               remx_ff <= rx[51:0];
               qx_ff   <= {qx_ff[20:0], 1'b0};
            end
            if (ry >= 53'(root_ff)) begin
               remy_ff <= 52'(ry - 53'(root_ff));
               qy_ff   <= {qy_ff[20:0], 1'b1};
            end else begin
               remy_ff <= ry[51:0];
               qy_ff   <= {qy_ff[20:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // Quotient fits: numerator < 2^52 and root >= 2^29 so result < 2^23;
   // clamp then apply sign.
   logic [21:0] mx, my;
   always_comb begin
      mx = (qx_ff > 22'(wvf_pkg::SPEED_MAX)) ? 22'(wvf_pkg::SPEED_MAX) : qx_ff;
      my = (qy_ff > 22'(wvf_pkg::SPEED_MAX)) ? 22'(wvf_pkg::SPEED_MAX) : qy_ff;
      vel_x = nx_ff ? -mx : mx;
      vel_y = ny_ff ? -my : my;
   end
endmodule

@@ src/wvf_controller.sv @@
// Sequencer for control ticks plus path bookkeeping and waypoint memory.
// Depends on wvf_pkg and the datapath status.
module wvf_controller #(parameter int MAX_WAYPOINTS = 64) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_mode,
   input  logic [31:0]       in_x,
   input  logic [31:0]       in_y,
   input  logic [15:0]       delay,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_zero,
   output logic              out_done,
   output logic [31:0]       cur_x,
   output logic [31:0]       cur_y,
   output logic [31:0]       wp_x,
   output logic [31:0]       wp_y,
   output wvf_pkg::cmd_type  cmd,
   input  wvf_pkg::stat_type stat
);
   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int LW = $clog2(MAX_WAYPOINTS + 1);
   // one divide step per numerator bit; quotient of up to 23 bits, 22 kept
   localparam int DIV_STEPS = 52;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001, S_READ = 10'b0000000010, S_LOAD = 10'b0000000100,
      S_SQ   = 10'b0000001000, S_TEST = 10'b0000010000, S_NORM = 10'b0000100000,
      S_RSQ  = 10'b0001000000, S_SQRT = 10'b0010000000, S_DIV  = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] mem_x [MAX_WAYPOINTS];
   logic [31:0] mem_y [MAX_WAYPOINTS];
   logic [31:0] cur_x_ff, cur_y_ff, rdx_ff, rdy_ff;
   logic [LW-1:0] len_ff, idx_ff;
   logic        fin_ff;
   logic [15:0] tick_ff;
   logic [5:0]  cnt_ff;
   logic        zero_ff, done_ff;
   logic        take;

   assign in_ready  = (state_ff == S_IDLE);
   assign take      = in_valid && in_ready;
   assign out_valid = (state_ff == S_OUT);
   assign out_zero  = zero_ff;
   assign out_done  = done_ff;
   assign cur_x = cur_x_ff;
   assign cur_y = cur_y_ff;
   assign wp_x  = rdx_ff;
   assign wp_y  = rdy_ff;

   // Waypoint memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (take && in_mode == wvf_pkg::MODE_APPEND && len_ff < LW'(MAX_WAYPOINTS)) begin
         mem_x[len_ff[AW-1:0]] <= in_x;
         mem_y[len_ff[AW-1:0]] <= in_y;
      end
      rdx_ff <= mem_x[idx_ff[AW-1:0]];
      rdy_ff <= mem_y[idx_ff[AW-1:0]];
   end

   always_comb begin
      cmd = '{op: wvf_pkg::OP_NONE, sel_y: 1'b0};
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (take && in_mode == wvf_pkg::MODE_TICK) begin
            if (tick_ff < delay || fin_ff || len_ff == '0 || idx_ff >= len_ff)
               state_in = S_OUT;
            else
               state_in = S_READ;
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: begin
            cmd.op = wvf_pkg::OP_LOAD;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = wvf_pkg::OP_SQ;
            cmd.sel_y = cnt_ff[0];
            if (cnt_ff[0]) state_in = S_TEST;
         end
         S_TEST: begin
            if (stat.near) state_in = S_IDLE;
            else if (stat.zero) state_in = S_OUT;
            else begin
               cmd.op = wvf_pkg::OP_PRIME;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (stat.norm_done) state_in = S_RSQ;
            else cmd.op = wvf_pkg::OP_NORM;
         end
         S_RSQ: begin
            cmd.op = wvf_pkg::OP_SQ;
            cmd.sel_y = cnt_ff[0];
            if (cnt_ff[0]) state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = wvf_pkg::OP_SQRT;
            if (cnt_ff == 6'd31) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = (cnt_ff == '0) ? wvf_pkg::OP_INIT : wvf_pkg::OP_DIV;
            if (cnt_ff == 6'(DIV_STEPS)) state_in = S_OUT;
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // State, step counter, tick bookkeeping and path registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_x_ff <= '0; cur_y_ff <= '0;
         len_ff <= '0; idx_ff <= '0; fin_ff <= 1'b0; tick_ff <= '0;
         cnt_ff <= '0; zero_ff <= 1'b1; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff != state_in) cnt_ff <= '0;
         else cnt_ff <= cnt_ff + 6'd1;
         if (take) begin
            case (in_mode)
               wvf_pkg::MODE_POS: begin
                  cur_x_ff <= in_x; cur_y_ff <= in_y;
               end
               wvf_pkg::MODE_APPEND:
                  if (len_ff < LW'(MAX_WAYPOINTS)) len_ff <= len_ff + LW'(1);
               wvf_pkg::MODE_CLEAR: begin
                  len_ff <= '0; idx_ff <= '0; fin_ff <= 1'b0;
               end
               default: begin
                  zero_ff <= 1'b1; done_ff <= 1'b0;
                  if (tick_ff < delay) tick_ff <= tick_ff + 16'd1;
                  else if (!fin_ff && len_ff != '0 && idx_ff >= len_ff) begin
                     fin_ff <= 1'b1; done_ff <= 1'b1;
                  end
               end
            endcase
         end
         if (state_ff == S_TEST && stat.near) idx_ff <= idx_ff + LW'(1);
         if (state_ff == S_DIV && state_in == S_OUT) zero_ff <= 1'b0;
      end
   end
endmodule

@@ src/waypoint_velocity_follower.sv @@
// Top level of the waypoint velocity follower: channel ports, config
// registers, controller and datapath. Depends on wvf_pkg, wvf_if.
//
//  channel | direction | payload
//  req     | in        | mode, x_val, y_val
//  rsp     | out       | vel_x, vel_y, done flag
//  csr     | in        | write enable, index, 25-bit data
//
// A steering tick runs read, load, 2 squaring steps, a threshold test,
// normalizing shifts, 2 more squaring steps, 32 root steps, divide setup and
// divide steps, then offers its response. A tick that reaches its waypoint
// returns to idle from the threshold test with no response. Position, append
// and clear requests leave it idle. Requests wait while a tick is in work or
// its response is unaccepted. Synchronous reset clears all control state.
`include "waypoint_velocity_follower_defines.svh"
module waypoint_velocity_follower #(parameter int MAX_WAYPOINTS = 64) (
   input  logic        clock,
   input  logic        reset,
   wvf_if.sink         req,
   wvf_if.source       rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   logic [15:0] delay_ff;
   logic [20:0] speed_ff;
   logic [24:0] thresh_ff;
   logic [31:0] cur_x, cur_y, wp_x, wp_y;
   logic [21:0] vx, vy;
   logic        out_zero, out_done;
   wvf_pkg::cmd_type  cmd;
   wvf_pkg::stat_type stat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0; speed_ff <= 21'd32768; thresh_ff <= 25'd65536;
      end else if (csr_we) begin
         case (csr_index)
            wvf_pkg::REG_DELAY:  delay_ff  <= csr_wdata[15:0];
            wvf_pkg::REG_SPEED:  speed_ff  <= csr_wdata[20:0];
            wvf_pkg::REG_THRESH: thresh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   wvf_controller #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_mode(req.data[65:64]), .in_x(req.data[63:32]), .in_y(req.data[31:0]),
      .delay(delay_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_zero, .out_done, .cur_x, .cur_y, .wp_x, .wp_y, .cmd, .stat
   );

   wvf_datapath u_dp (
      .clock, .cmd, .wp_x, .wp_y, .cur_x, .cur_y,
      .thresh(thresh_ff), .speed(speed_ff), .stat, .vel_x(vx), .vel_y(vy)
   );

   // Response payload: vel_x, vel_y, done flag.
   assign rsp.data = {out_zero ? 22'd0 : vx, out_zero ? 22'd0 : vy, out_done};

   `WVF_ASSERT_IMPL(a_no_both, clock, reset, !(req.ready && rsp.valid))
   `WVF_ASSERT_IMPL(a_done_zero, clock, reset, (rsp.valid && rsp.data[0]) |-> out_zero)
endmodule

@@ sim/waypoint_velocity_follower_checker.sv @@
// Checker for the waypoint velocity follower: mirrors the registers, predicts
// each velocity response and compares it field by field. Depends on wvf_pkg, wvf_if.
module waypoint_velocity_follower_checker (
   input  logic        clock,
   input  logic        reset,
   wvf_if              req,
   wvf_if              rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_wdata,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 64;

   typedef struct packed {
      logic [21:0] vel_x;
      logic [21:0] vel_y;
      logic        done_pulse;
   } velocity_cmd_type;

   // Register mirror.
   logic [15:0] delay_ticks;
   logic [20:0] speed;
   logic [24:0] threshold;

   // Follower state mirror.
   logic [31:0] pos_x, pos_y;
   logic [31:0] path_x [STORE_DEPTH];
   logic [31:0] path_y [STORE_DEPTH];
   int          path_len, target, ticks_seen;
   logic        path_done;

   velocity_cmd_type expected_cmds[$];

   // Floor of the square root, bit by bit.
   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Applies one request to the mirror; returns 1 when a response is due.
   function automatic bit follow_request(logic [1:0] mode, logic [31:0] xv, logic [31:0] yv,
                                         output velocity_cmd_type cmd);
      logic signed [33:0] dx, dy, mx, my;
      logic [63:0] ax, ay, m, thr, r, spd, vx, vy;
      cmd = '0;
      case (mode)
         wvf_pkg::MODE_POS: begin
            pos_x = xv;
            pos_y = yv;
            return 0;
         end
         wvf_pkg::MODE_APPEND: begin
            if (path_len < STORE_DEPTH) begin
               path_x[path_len] = xv;
               path_y[path_len] = yv;
               path_len++;
            end
            return 0;
         end
         wvf_pkg::MODE_CLEAR: begin
            path_len = 0;
            target = 0;
            path_done = 0;
            return 0;
         end
         default: ;
      endcase
      // Control tick from here on.
      if (ticks_seen < int'(delay_ticks)) begin
         ticks_seen++;
         return 1;
      end
      if (path_done || path_len == 0) return 1;
      if (target >= path_len) begin
         path_done = 1;
         cmd.done_pulse = 1;
         return 1;
      end
      dx = {{2{path_x[target][31]}}, path_x[target]} - {{2{pos_x[31]}}, pos_x};
      dy = {{2{path_y[target][31]}}, path_y[target]} - {{2{pos_y[31]}}, pos_y};
      mx = dx[33] ? -dx : dx;
      my = dy[33] ? -dy : dy;
      ax = {30'd0, mx};
      ay = {30'd0, my};
      thr = {39'd0, threshold};
      // Inside the arrival disc: advance without a response.
      if (ax < thr && ay < thr && (ax * ax + ay * ay) < thr * thr) begin
         target++;
         return 0;
      end
      if (ax == 0 && ay == 0) return 1;
      m = (ax > ay) ? ax : ay;
      while (m >= (64'd1 << 30)) begin
         m = m >> 1; ax = ax >> 1; ay = ay >> 1;
      end
      while (m < (64'd1 << 29)) begin
         m = m << 1; ax = ax << 1; ay = ay << 1;
      end
      r = root_floor(ax * ax + ay * ay);
      if (r == 0) return 1;
      spd = (speed > wvf_pkg::SPEED_MAX) ? 64'(wvf_pkg::SPEED_MAX) : 64'(speed);
      vx = (spd * ax + r / 2) / r;
      vy = (spd * ay + r / 2) / r;
      if (vx > 64'(wvf_pkg::SPEED_MAX)) vx = 64'(wvf_pkg::SPEED_MAX);
      if (vy > 64'(wvf_pkg::SPEED_MAX)) vy = 64'(wvf_pkg::SPEED_MAX);
      cmd.vel_x = dx[33] ? 22'(-vx) : 22'(vx);
      cmd.vel_y = dy[33] ? 22'(-vy) : 22'(vy);
      return 1;
   endfunction

   always @(posedge clock) begin
      velocity_cmd_type exp_cmd, got_cmd;
      if (reset) begin
         delay_ticks = 0;
         speed = 21'd32768;
         threshold = 25'd65536;
         pos_x = 0;
         pos_y = 0;
         path_len = 0;
         target = 0;
         ticks_seen = 0;
         path_done = 0;
         expected_cmds.delete();
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               wvf_pkg::REG_DELAY:  delay_ticks = csr_wdata[15:0];
               wvf_pkg::REG_SPEED:  speed = csr_wdata[20:0];
               wvf_pkg::REG_THRESH: threshold = csr_wdata;
               default: ;
            endcase
         end
         // Compare an accepted response with the oldest prediction.
         if (rsp.valid && rsp.ready) begin
            got_cmd = rsp.data;
            if (expected_cmds.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected response %h at %0t", got_cmd, $realtime);
            end else begin
               exp_cmd = expected_cmds.pop_front();
               if (got_cmd.vel_x !== exp_cmd.vel_x || got_cmd.vel_y !== exp_cmd.vel_y ||
                   got_cmd.done_pulse !== exp_cmd.done_pulse) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch at %0t: vel_x exp %h got %h, ",
                               "vel_y exp %h got %h, done exp %b got %b"},
                              $realtime, exp_cmd.vel_x, got_cmd.vel_x, exp_cmd.vel_y,
                              got_cmd.vel_y, exp_cmd.done_pulse, got_cmd.done_pulse);
               end
            end
         end
         // Predict the effect of an accepted request.
         if (req.valid && req.ready) begin
            if (follow_request(req.data[65:64], req.data[63:32], req.data[31:0], exp_cmd))
               expected_cmds.insert(expected_cmds.size(), exp_cmd);
         end
      end
      pending = expected_cmds.size();
   end
endmodule

@@ sim/waypoint_velocity_follower_tb.sv @@
// Testbench top: clock, reset, request stimulus, response back-pressure and
// register writes. Depends on wvf_pkg, wvf_if, the block and its checker.
module waypoint_velocity_follower_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = wvf_pkg::REG_DELAY;
   logic [24:0] csr_wdata = 0;
   int          failures, pending;
   int          cycles = 0;
   int          hold_len = 0;
   bit          hold_req = 0;
   bit          hold_taken = 0;
   bit          calm = 0;
   int          sent = 0;
   logic [24:0] cur_thresh = 25'd65536;
   logic [31:0] pts_x [8];
   logic [31:0] pts_y [8];

   wvf_if #(.W(66)) req_ch ();
   wvf_if #(.W(45)) rsp_ch ();

   waypoint_velocity_follower u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   waypoint_velocity_follower_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   always #2 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("waypoint_velocity_follower_tb: FAIL");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken = 1;
         hold_len = 400;
      end
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_len > 0) begin
         hold_len--;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
      end
   end

   // Offers one request and waits until it is taken.
   task automatic send(logic [1:0] mode, logic [31:0] xv, logic [31:0] yv);
      if (!calm && $urandom_range(0, 99) < 19) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.data <= {mode, xv, yv};
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
   endtask

   // Waits until every response has arrived and the block has gone quiet.
   task automatic drain();
      req_ch.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic set_regs(logic [15:0] delay, logic [20:0] spd, logic [24:0] thr);
      csr_we <= 1;
      csr_index <= wvf_pkg::REG_DELAY;
      csr_wdata <= 25'(delay);
      @(negedge clock);
      csr_index <= wvf_pkg::REG_SPEED;
      csr_wdata <= 25'(spd);
      @(negedge clock);
      csr_index <= wvf_pkg::REG_THRESH;
      csr_wdata <= thr;
      @(negedge clock);
      csr_we <= 0;
      cur_thresh = thr;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return 32'($signed($urandom_range(0, 134217727)) - 67108864);
      endcase
   endfunction

   // A point within reach of a waypoint for the current threshold.
   function automatic logic [31:0] nudge(logic [31:0] v);
      int span;
      span = (cur_thresh > 4) ? int'(cur_thresh / 3) : 0;
      return v + 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // One well-formed path: clear, append points, then steer through them.
   task automatic run_path(int count);
      logic [31:0] px, py;
      send(wvf_pkg::MODE_CLEAR, $urandom, $urandom);
      for (int i = 0; i < count; i++) begin
         px = rand_coord();
         py = rand_coord();
         if (i < 8) begin
            pts_x[i] = px;
            pts_y[i] = py;
         end
         send(wvf_pkg::MODE_APPEND, px, py);
      end
      for (int j = 0; j < ((count < 8) ? count : 8) + 2; j++) begin
         if (j < 8 && j < count && $urandom_range(0, 1))
            send(wvf_pkg::MODE_POS, nudge(pts_x[j]), nudge(pts_y[j]));
         else
            send(wvf_pkg::MODE_POS, rand_coord(), rand_coord());
         send(wvf_pkg::MODE_TICK, $urandom, $urandom);
         send(wvf_pkg::MODE_TICK, $urandom, $urandom);
         // Occasional noise between ticks.
         if ($urandom_range(0, 9) == 0)
            send(2'($urandom_range(0, 3)), $urandom, $urandom);
      end
   endtask

   task automatic run_phase(int budget);
      int stop;
      stop = sent + budget;
      while (sent < stop) begin
         calm = ($urandom_range(0, 5) == 0);
         run_path($urandom_range(0, 15) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 6));
      end
      calm = 0;
   endtask

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty path, extreme coordinates, arrival, done pulse, finish.
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_POS, 0, 0);
      send(wvf_pkg::MODE_APPEND, 32'h7fff_ffff, 32'h8000_0000);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_APPEND, 32'hffff_ffff, 0);
      send(wvf_pkg::MODE_POS, 32'h8000_0000, 32'h7fff_ffff);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_POS, 32'h7fff_ffff, 32'h8000_0000);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_POS, 32'hffff_ffff, 1);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_CLEAR, 0, 0);
      send(wvf_pkg::MODE_TICK, 0, 0);

      // Directed: start delay, speed above range, zero threshold, zero offset.
      drain();
      set_regs(16'd3, 21'h1f_ffff, 25'd0);
      repeat (4) send(wvf_pkg::MODE_TICK, $urandom, $urandom);
      send(wvf_pkg::MODE_POS, 5, 5);
      send(wvf_pkg::MODE_APPEND, 5, 5);
      send(wvf_pkg::MODE_TICK, 0, 0);
      send(wvf_pkg::MODE_APPEND, 100, -7);
      send(wvf_pkg::MODE_TICK, 0, 0);

      // Full store: more appends than fit.
      drain();
      set_regs(16'd0, 21'd1048576, 25'd16777216);
      run_path(68);
      run_phase(50);

      // Long response hold-off while requests keep coming.
      drain();
      set_regs(16'd0, 21'($urandom_range(0, 2097151)), 25'h1ff_ffff);
      hold_req = 1;
      run_phase(60);

      // Sender waits for every response midway.
      drain();
      set_regs(16'($urandom_range(1, 8)), 21'($urandom_range(0, 1048576)),
               25'($urandom_range(0, 8388608)));
      run_phase(30);
      drain();
      run_phase(30);

      drain();
      set_regs(16'd65535, 21'd0, 25'd1);
      run_phase(20);

      drain();
      set_regs(16'd0, 21'd32768, 25'd65536);
      run_phase(60);

      drain();
      set_regs(16'd0, 21'($urandom_range(0, 2097151)), 25'($urandom_range(0, 33554431)));
      run_phase(60);

      drain();
      if (failures == 0 && pending == 0) begin
         $display("waypoint_velocity_follower_tb: PASS");
      end else begin
         $display("waypoint_velocity_follower_tb: FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+src
src/wvf_pkg.sv
src/wvf_if.sv
src/wvf_datapath.sv
src/wvf_controller.sv
src/waypoint_velocity_follower.sv
sim/waypoint_velocity_follower_checker.sv
sim/waypoint_velocity_follower_tb.sv
